// ===== hw/rtl/lcc_pkg.sv =====
`timescale 1ns / 1ps
// lcc_pkg: types, constants and small helper functions for the card number checker
// used by lcc_kind_check and luhn_card_number_checker; depends on nothing else
package lcc_pkg;

   localparam int unsigned DIGIT_W = 4;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned KIND_W  = 2;

   // card kind register codes
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEAD4   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RANGE5  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LISTED  = 2'd3;
   localparam logic [KIND_W-1:0] KIND_DEFAULT = KIND_LEAD4;

   // lengths
   localparam logic [COUNT_W-1:0] LEN_13 = 7'd13;
   localparam logic [COUNT_W-1:0] LEN_16 = 7'd16;
   localparam logic [COUNT_W-1:0] LEN_19 = 7'd19;

   // prefixes held as packed bcd, so numeric order equals bcd order
   localparam logic [3:0]  PFX1_LEAD4    = 4'h4;
   localparam logic [7:0]  PFX2_LOW      = 8'h51;
   localparam logic [7:0]  PFX2_HIGH     = 8'h55;
   localparam logic [23:0] PFX6_LOW      = 24'h222100;
   localparam logic [23:0] PFX6_HIGH     = 24'h272099;
   localparam logic [15:0] PFX4_A        = 16'h4026;
   localparam logic [15:0] PFX4_B        = 16'h4508;
   localparam logic [15:0] PFX4_C        = 16'h4844;
   localparam logic [15:0] PFX4_D        = 16'h4913;
   localparam logic [15:0] PFX4_E        = 16'h4917;
   localparam logic [23:0] PFX6_LISTED   = 24'h417500;
   localparam int unsigned PREFIX_DIGITS = 6;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last_digit;
   } req_type;

   typedef struct packed {
      logic               checksum_ok;
      logic               kind_ok;
      logic [DIGIT_W-1:0] computed_check;
      logic [DIGIT_W-1:0] entered_check;
      logic [COUNT_W-1:0] digit_count;
   } rsp_type;

   // what the kind rule needs to know about a finished number
   typedef struct packed {
      logic [COUNT_W-1:0]                 length;
      logic                               too_long;
      logic [PREFIX_DIGITS*DIGIT_W-1:0]   prefix;
   } kind_query_type;

   // codes ten to fifteen count as the digit minus ten
   function automatic logic [DIGIT_W-1:0] fold_digit(input logic [DIGIT_W-1:0] raw);
      logic [DIGIT_W-1:0] res;
      res = (raw > 4'd9) ? raw - 4'd10 : raw;
      return res;
   endfunction

   function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W:0] t;
      logic [DIGIT_W:0] r;
      t = {d, 1'b0};
      r = (t > 5'd9) ? t - 5'd9 : t;
      return r[DIGIT_W-1:0];
   endfunction

   // both operands in 0..9
   function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
      logic [DIGIT_W:0] s;
      logic [DIGIT_W:0] r;
      s = {1'b0, a} + {1'b0, b};
      r = (s > 5'd9) ? s - 5'd10 : s;
      return r[DIGIT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/lcc_kind_check.sv =====
`timescale 1ns / 1ps
// lcc_kind_check: length and prefix rule for the configured card kind
// pure combinational; depends on lcc_pkg
module lcc_kind_check (
   input  logic [lcc_pkg::KIND_W-1:0] card_kind,
   input  lcc_pkg::kind_query_type    query,
   output logic                       kind_ok
);
   import lcc_pkg::*;

   logic [3:0]  pfx1;
   logic [7:0]  pfx2;
   logic [15:0] pfx4;
   logic [23:0] pfx6;
   logic        len_16;
   logic        lead4_ok;
   logic        range5_ok;
   logic        listed_ok;

   assign pfx6 = query.prefix;
   assign pfx4 = query.prefix[23:8];
   assign pfx2 = query.prefix[23:16];
   assign pfx1 = query.prefix[23:20];
   assign len_16 = (query.length == LEN_16);

   assign lead4_ok = ((query.length == LEN_13) || len_16 || (query.length == LEN_19))
                     && (pfx1 == PFX1_LEAD4);
   assign range5_ok = len_16 && (((pfx2 >= PFX2_LOW) && (pfx2 <= PFX2_HIGH)) ||
                                 ((pfx6 >= PFX6_LOW) && (pfx6 <= PFX6_HIGH)));
   assign listed_ok = len_16 && ((pfx4 == PFX4_A) || (pfx4 == PFX4_B) ||
                                 (pfx4 == PFX4_C) || (pfx4 == PFX4_D) ||
                                 (pfx4 == PFX4_E) || (pfx6 == PFX6_LISTED));

   always_comb begin
      kind_ok = 1'b0;
      if (!query.too_long) begin
         unique case (card_kind)
            KIND_LEAD4:  kind_ok = lead4_ok;
            KIND_RANGE5: kind_ok = range5_ok;
            KIND_LISTED: kind_ok = listed_ok;
            KIND_NONE:   kind_ok = 1'b0;
            default:     kind_ok = 1'b0;
         endcase
      end
   end

endmodule

// ===== hw/rtl/luhn_card_number_checker.sv =====
`timescale 1ns / 1ps
// luhn_card_number_checker: streaming luhn check digit and card kind checker
// depends on lcc_pkg and lcc_kind_check
//
// Usage:
//   req channel: one decimal digit per transaction, most significant first,
//   last_digit set on the check digit. rsp channel: one transaction per number,
//   sent for the transaction that carried last_digit.
//   csr channel: writes card_kind (0 to 3); csr_ready is always high. The user
//   makes writes only while no number is in flight; the block does not enforce it.
//   A digit taken in sits in the input register and is then folded into the
//   running sums; for a last digit the result register is loaded and rsp_valid
//   rises. Throughput is one digit per clock while req_stall is low; the path from
//   input register to sums is a mod-10 add, to result register a few compares.
//   When rsp_stall is high the result register holds; one further last digit
//   can wait in the input register, after which req_stall rises. Digits that
//   are not last keep flowing in one per clock regardless of rsp_stall.
//   Reset clears the sums, count and prefix and sets card_kind to 1.
//   digit_count saturates at MAX_DIGITS; such a number never fits a kind.
module luhn_card_number_checker #(
   parameter int unsigned MAX_DIGITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lcc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lcc_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lcc_pkg::KIND_W-1:0] csr_data
);
   import lcc_pkg::*;

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_DIGITS);

   // input register
   logic                               s1_valid_ff, s1_valid_in;
   req_type                            s1_data_ff;
   // per-number state
   logic [DIGIT_W-1:0]                 sum_even_ff, sum_even_in;
   logic [DIGIT_W-1:0]                 sum_odd_ff, sum_odd_in;
   logic [COUNT_W-1:0]                 count_ff, count_in;
   logic                               parity_ff, parity_in;
   logic [PREFIX_DIGITS*DIGIT_W-1:0]   prefix_ff, prefix_in;
   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   rsp_type                            rsp_data_ff, rsp_data_in;
   logic [KIND_W-1:0]                  card_kind_ff;

   logic                               out_free;
   logic                               s1_move;
   logic [DIGIT_W-1:0]                 d;
   logic [DIGIT_W-1:0]                 d_dbl;
   logic [DIGIT_W-1:0]                 sel_sum;
   logic [DIGIT_W-1:0]                 computed;
   logic                               head_digit;
   logic                               too_long;
   logic [PREFIX_DIGITS*DIGIT_W-1:0]   prefix_next;
   kind_query_type                     query;
   logic                               kind_ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // a non-last digit only touches state, so it never waits for the result side
   assign s1_move  = s1_valid_ff && (!s1_data_ff.last_digit || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign csr_ready = 1'b1;

   assign d          = fold_digit(s1_data_ff.digit);
   assign d_dbl      = luhn_double(d);
   assign sel_sum    = parity_ff ? sum_even_ff : sum_odd_ff;
   assign computed   = (sel_sum == 4'd0) ? 4'd0 : 4'd10 - sel_sum;
   assign head_digit = (count_ff < COUNT_W'(PREFIX_DIGITS));
   assign too_long   = (count_ff >= MaxCount);
   assign prefix_next = head_digit ? {prefix_ff[PREFIX_DIGITS*DIGIT_W-DIGIT_W-1:0], d}
                                   : prefix_ff;

   assign query.length   = too_long ? MaxCount : count_ff + 7'd1;
   assign query.too_long = too_long;
   assign query.prefix   = prefix_next;

   lcc_kind_check u_kind_check (
      .card_kind (card_kind_ff),
      .query     (query),
      .kind_ok   (kind_ok)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move || !s1_valid_ff) begin
         s1_valid_in = req_valid;
      end

      sum_even_in = sum_even_ff;
      sum_odd_in  = sum_odd_ff;
      count_in    = count_ff;
      parity_in   = parity_ff;
      prefix_in   = prefix_ff;
      if (s1_move) begin
         if (s1_data_ff.last_digit) begin
            sum_even_in = '0;
            sum_odd_in  = '0;
            count_in    = '0;
            parity_in   = 1'b0;
            prefix_in   = '0;
         end else begin
            sum_even_in = add_mod10(sum_even_ff, parity_ff ? d : d_dbl);
            sum_odd_in  = add_mod10(sum_odd_ff, parity_ff ? d_dbl : d);
            parity_in   = !parity_ff;
            prefix_in   = prefix_next;
            if (!too_long) begin
               count_in = count_ff + 7'd1;
            end
         end
      end

      rsp_data_in.checksum_ok    = (s1_data_ff.digit == computed);
      rsp_data_in.kind_ok        = kind_ok;
      rsp_data_in.computed_check = computed;
      rsp_data_in.entered_check  = s1_data_ff.digit;
      rsp_data_in.digit_count    = query.length;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_move && s1_data_ff.last_digit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_even_ff  <= '0;
         sum_odd_ff   <= '0;
         count_ff     <= '0;
         parity_ff    <= 1'b0;
         prefix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         card_kind_ff <= KIND_DEFAULT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         sum_even_ff  <= sum_even_in;
         sum_odd_ff   <= sum_odd_in;
         count_ff     <= count_in;
         parity_ff    <= parity_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            card_kind_ff <= csr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (s1_move && s1_data_ff.last_digit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for luhn_card_number_checker, streams card numbers digit by digit
// depends on lcc_pkg and the checker rtl; the scoreboard class below predicts every result

module tb;
   import lcc_pkg::*;

   class luhn_tracker;
      logic [KIND_W-1:0] card_kind;
      int unsigned       max_digits;
      int unsigned       sum_even_dbl;
      int unsigned       sum_odd_dbl;
      int unsigned       digits_in;
      int unsigned       lead_value;
      bit                odd_count;
      rsp_type           expected_results[$];
      int unsigned       mismatches;
      int unsigned       results_checked;
      int unsigned       good_checksums;
      int unsigned       good_kinds;

      function new(int unsigned max_len);
         max_digits = max_len;
         card_kind  = KIND_DEFAULT;
         clear_number();
      endfunction

      function void clear_number();
         sum_even_dbl = 0;
         sum_odd_dbl  = 0;
         digits_in    = 0;
         lead_value   = 0;
         odd_count    = 1'b0;
      endfunction

      function int unsigned doubled(int unsigned d);
         return (2 * d > 9) ? 2 * d - 9 : 2 * d;
      endfunction

      function bit kind_fits(int unsigned len, bit too_long, int unsigned pre6);
         int unsigned p1;
         int unsigned p2;
         int unsigned p4;
         p1 = pre6 / 100000;
         p2 = pre6 / 10000;
         p4 = pre6 / 100;
         if (too_long)
            return 1'b0;
         case (card_kind)
            KIND_LEAD4: begin
               return (len == 13 || len == 16 || len == 19) && p1 == 4;
            end
            KIND_RANGE5: begin
               return len == 16 && ((p2 >= 51 && p2 <= 55) ||
                                    (pre6 >= 222100 && pre6 <= 272099));
            end
            KIND_LISTED: begin
               return len == 16 && (p4 == 4026 || p4 == 4508 || p4 == 4844 || p4 == 4913 ||
                                    p4 == 4917 || pre6 == 417500);
            end
            default: begin
               return 1'b0;
            end
         endcase
      endfunction

      // folds one accepted digit into the running sums, queues a result on the last one
      function void note_digit(req_type item);
         int unsigned raw;
         int unsigned d;
         int unsigned s;
         int unsigned len;
         int unsigned pre6;
         bit          too_long;
         rsp_type     exp_rsp;
         raw = 32'(item.digit);
         d   = (raw > 9) ? raw - 10 : raw;
         if (item.last_digit) begin
            // pick the sum in which the digit just before the check digit was doubled
            s        = odd_count ? sum_even_dbl : sum_odd_dbl;
            too_long = digits_in >= max_digits;
            len      = too_long ? max_digits : digits_in + 1;
            pre6     = lead_value;
            if (digits_in < 6)
               pre6 = pre6 * 10 + d;
            exp_rsp.computed_check = DIGIT_W'((10 - s) % 10);
            exp_rsp.entered_check  = DIGIT_W'(raw);
            exp_rsp.checksum_ok    = (raw == (10 - s) % 10);
            exp_rsp.kind_ok        = kind_fits(len, too_long, pre6);
            exp_rsp.digit_count    = COUNT_W'(len);
            expected_results.push_back(exp_rsp);
            clear_number();
         end else begin
            if (!odd_count) begin
               sum_even_dbl = (sum_even_dbl + doubled(d)) % 10;
               sum_odd_dbl  = (sum_odd_dbl + d) % 10;
            end else begin
               sum_odd_dbl  = (sum_odd_dbl + doubled(d)) % 10;
               sum_even_dbl = (sum_even_dbl + d) % 10;
            end
            odd_count = !odd_count;
            if (digits_in < 6)
               lead_value = lead_value * 10 + d;
            if (digits_in < max_digits)
               digits_in = digits_in + 1;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected result: ok=%0d kind=%0d calc=%0d entered=%0d count=%0d",
                        got.checksum_ok, got.kind_ok, got.computed_check, got.entered_check,
                        got.digit_count);
            return;
         end
         want = expected_results.pop_front();
         results_checked = results_checked + 1;
         if (want.checksum_ok)
            good_checksums = good_checksums + 1;
         if (want.kind_ok)
            good_kinds = good_kinds + 1;
         if (got.checksum_ok !== want.checksum_ok || got.kind_ok !== want.kind_ok ||
             got.computed_check !== want.computed_check ||
             got.entered_check !== want.entered_check ||
             got.digit_count !== want.digit_count) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("result %0d mismatch at %0t: ok %0d/%0d kind %0d/%0d calc %0d/%0d %s",
                        results_checked, $realtime, want.checksum_ok, got.checksum_ok,
                        want.kind_ok, got.kind_ok, want.computed_check, got.computed_check,
                        $sformatf("entered %0d/%0d count %0d/%0d (expected/actual)",
                                  want.entered_check, got.entered_check,
                                  want.digit_count, got.digit_count));
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   localparam int unsigned MAX_DIGITS = 64;
   localparam int unsigned LISTED4 [5] = '{4026, 4508, 4844, 4913, 4917};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [KIND_W-1:0] csr_data = '0;

   luhn_tracker board;
   int unsigned number_digits[$];
   int unsigned digits_sent = 0;
   int unsigned stall_left = 0;
   bit          quiet = 1'b0;

   luhn_card_number_checker #(.MAX_DIGITS(MAX_DIGITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check every transaction, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_data);
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
         end else if (!quiet && !rsp_stall && $urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("tb NOT OK");
      $finish;
   end

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic set_kind(logic [KIND_W-1:0] kind);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= kind;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.card_kind = kind;
   endtask

   task automatic send_digit(int unsigned value, bit last, bit calm);
      req_type item;
      item.digit      = DIGIT_W'(value);
      item.last_digit = last;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_digit(item);
      digits_sent = digits_sent + 1;
   endtask

   task automatic send_number(bit calm);
      for (int i = 0; i < number_digits.size(); i++)
         send_digit(number_digits[i], i == number_digits.size() - 1, calm);
   endtask

   task automatic add_digits(int unsigned value, int unsigned count);
      int unsigned div;
      div = 1;
      for (int i = 1; i < count; i++)
         div = div * 10;
      for (int i = 0; i < count; i++) begin
         number_digits.push_back((value / div) % 10);
         div = div / 10;
      end
   endtask

   task automatic fill_to(int unsigned len, int unsigned top);
      while (number_digits.size() < len)
         number_digits.push_back($urandom_range(0, top));
   endtask

   // luhn digit that completes the digits held so far, rightmost of them doubled
   function automatic int unsigned luhn_check_for();
      int unsigned sum;
      int unsigned v;
      sum = 0;
      for (int i = 0; i < number_digits.size(); i++) begin
         v = number_digits[number_digits.size() - 1 - i];
         if (i % 2 == 0)
            v = (v * 2 > 9) ? v * 2 - 9 : v * 2;
         sum = sum + v;
      end
      return (10 - sum % 10) % 10;
   endfunction

   task automatic add_prefix(logic [KIND_W-1:0] kind);
      int unsigned pick;
      pick = $urandom_range(0, 6);
      case (kind)
         KIND_LEAD4: begin
            add_digits(4, 1);
         end
         KIND_RANGE5: begin
            if (pick < 2)
               add_digits($urandom_range(51, 55), 2);
            else if (pick < 4)
               add_digits($urandom_range(222100, 272099), 6);
            else if (pick == 4)
               add_digits($urandom_range(0, 1) ? 222100 : 272099, 6);
            else if (pick == 5)
               add_digits($urandom_range(0, 1) ? 50 : 56, 2);
            else
               add_digits($urandom_range(0, 1) ? 222099 : 272100, 6);
         end
         KIND_LISTED: begin
            if (pick < 5)
               add_digits(LISTED4[pick], 4);
            else if (pick == 5)
               add_digits(417500, 6);
            else if ($urandom_range(0, 1))
               add_digits(4027, 4);
            else
               add_digits(417501, 6);
         end
         default: begin
            add_digits($urandom_range(0, 9), 1);
         end
      endcase
   endtask

   // well-formed number for a card kind, sometimes with a wrong check digit or length
   task automatic build_card(logic [KIND_W-1:0] kind);
      int unsigned len;
      int unsigned check;
      number_digits.delete();
      add_prefix(kind);
      if (kind == KIND_LEAD4)
         len = 13 + 3 * $urandom_range(0, 2);
      else
         len = 16;
      if ($urandom_range(0, 7) == 0)
         len = $urandom_range(0, 1) ? len + 1 : len - 1;
      fill_to(len - 1, 9);
      check = luhn_check_for();
      if ($urandom_range(0, 3) == 0)
         check = (check + $urandom_range(1, 9)) % 10;
      number_digits.push_back(check);
   endtask

   task automatic build_random_number(logic [KIND_W-1:0] kind, bit force_long);
      int unsigned sel;
      int unsigned len;
      sel = force_long ? 99 : $urandom_range(0, 99);
      number_digits.delete();
      if (sel < 60) begin
         build_card(($urandom_range(0, 4) == 0) ? KIND_W'($urandom_range(0, 3)) : kind);
      end else if (sel < 75) begin
         fill_to($urandom_range(1, 20), 9);
      end else if (sel < 85) begin
         // codes above nine, on any digit including the last
         fill_to($urandom_range(1, 20), 15);
      end else if (sel < 90) begin
         len = $urandom_range(1, 12);
         add_prefix(kind);
         while (number_digits.size() > len)
            number_digits.delete(number_digits.size() - 1);
         fill_to(len, 9);
      end else if (sel < 97) begin
         add_prefix(KIND_W'($urandom_range(0, 3)));
         fill_to($urandom_range(12, 20), 9);
      end else begin
         fill_to($urandom_range(MAX_DIGITS - 2, MAX_DIGITS + 6), 9);
      end
   endtask

   task automatic run_phase(logic [KIND_W-1:0] kind, int unsigned budget, bit long_first);
      int unsigned start;
      bit          first;
      start = digits_sent;
      first = long_first;
      while (digits_sent - start < budget) begin
         build_random_number(kind, first);
         first = 1'b0;
         send_number(quiet || $urandom_range(0, 3) == 0);
         if ($urandom_range(0, 49) == 0)
            wait_drained();
      end
   endtask

   initial begin
      board = new(MAX_DIGITS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: single digit numbers with codes at both ends, a two digit number, one 16-digit number
      number_digits = '{0};
      send_number(1'b0);
      number_digits = '{9};
      send_number(1'b0);
      number_digits = '{15};
      send_number(1'b0);
      number_digits = '{15, 9};
      send_number(1'b0);
      number_digits = '{4, 9, 0, 9, 0, 9, 0, 9, 0, 9, 0, 9, 0, 9, 0};
      number_digits.push_back(luhn_check_for());
      send_number(1'b1);

      set_kind(KIND_RANGE5);
      run_phase(KIND_RANGE5, 250, 1'b1);
      set_kind(KIND_LISTED);
      run_phase(KIND_LISTED, 250, 1'b0);
      set_kind(KIND_NONE);
      run_phase(KIND_NONE, 250, 1'b0);
      set_kind(KIND_LEAD4);
      quiet <= 1'b1;
      run_phase(KIND_LEAD4, 250, 1'b1);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d numbers from %0d digits across all four card kind settings",
               board.results_checked, digits_sent);
      $display("%0d carried a good check digit, %0d fitted their kind, %0d mismatches",
               board.good_checksums, board.good_kinds, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule

// ===== luhn_card_number_checker.f =====
hw/rtl/lcc_pkg.sv
hw/rtl/lcc_kind_check.sv
hw/rtl/luhn_card_number_checker.sv
test/tb.sv
